// File: design/triangle_scanline_span_walker_top_assert.svh
// assertion helpers used by the span walker controller
`ifndef TRIANGLE_SCANLINE_SPAN_WALKER_TOP_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_WALKER_TOP_ASSERT_SVH

// plain property checked on every rising clock edge outside reset
`define TSW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define TSW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tsw_pkg.sv
`default_nettype none
package tsw_pkg;

   localparam int LINE_W = 10;
   localparam int X_W    = 11;
   localparam int X_MAX  = 2047;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_LINES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_LIMIT  = 2'd2;

   localparam logic [LINE_W-1:0] ACTIVE_RESET = 10'd480;
   localparam logic [X_W-1:0]    LEFT_RESET   = 11'd224;
   localparam logic [X_W-1:0]    RIGHT_RESET  = 11'd1085;

   typedef enum logic [1:0] {
      PH_DONE   = 2'd0,
      PH_TOP    = 2'd1,
      PH_BOTTOM = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      DIV_TWO = 2'd0,
      DIV_TOP = 2'd1,
      DIV_BOT = 2'd2
   } div_kind_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'd0,
      S_LOAD   = 4'd1,
      S_DIV    = 4'd2,
      S_ENTER  = 4'd3,
      S_ENTER2 = 4'd4,
      S_SETTLE = 4'd5,
      S_ADD    = 4'd6,
      S_SPAN   = 4'd7,
      S_CLAMP  = 4'd8,
      S_OUT    = 4'd9
   } state_type;

   typedef struct packed {
      logic         load;
      logic         clear_out;
      logic         div_start;
      logic         div_store;
      div_kind_type div_kind;
      logic         enter;
      logic         enter_add;
      logic         enter_bottom;
      logic         step_add;
      logic         span_calc;
      logic         span_out;
      logic         set_finish;
      logic         finish_val;
   } cmd_type;

   typedef struct packed {
      logic flat_total;
      logic flat_top;
      logic flat_bot;
      logic div_done;
      logic need_next;
   } status_type;

endpackage
`default_nettype wire

// File: design/tsw_div.sv
`default_nettype none
module tsw_div #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [COORD_BITS:0]            dx,
   input  wire logic signed [COORD_BITS:0]            dy,
   output logic                                       done,
   output logic signed [COORD_BITS+FRAC_BITS:0]       quot
);
   localparam int NUM_W = COORD_BITS + FRAC_BITS;
   localparam int REM_W = COORD_BITS + 2;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [COORD_BITS:0] dx_mag;
   logic [REM_W-1:0] rem_sh;

   always_comb begin
      dx_mag  = dx[COORD_BITS] ? COORD_BITS'(0) - dx : dx;
      rem_sh  = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      if (start) begin
         num_in  = {dx_mag[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         q_in    = '0;
         den_in  = {1'b0, dy};
         neg_in  = dx[COORD_BITS];
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (rem_sh >= den_ff) begin
            rem_in = rem_sh - den_ff;
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   // magnitude quotient with sign restored gives truncation toward zero
   assign quot = neg_ff ? (NUM_W+1)'(0) - {1'b0, q_ff} : {1'b0, q_ff};
endmodule
`default_nettype wire

// File: design/tsw_dp.sv
`default_nettype none
module tsw_dp #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tsw_pkg::cmd_type              cmd,
   output tsw_pkg::status_type                status,
   input  wire logic signed [COORD_BITS-1:0]  ax,
   input  wire logic signed [COORD_BITS-1:0]  ay,
   input  wire logic signed [COORD_BITS-1:0]  bx,
   input  wire logic signed [COORD_BITS-1:0]  by,
   input  wire logic signed [COORD_BITS-1:0]  cx,
   input  wire logic signed [COORD_BITS-1:0]  cy,
   input  wire logic [tsw_pkg::LINE_W-1:0]    active_lines,
   input  wire logic [tsw_pkg::X_W-1:0]       left_limit,
   input  wire logic [tsw_pkg::X_W-1:0]       right_limit,
   output logic                               span_valid,
   output logic [tsw_pkg::LINE_W-1:0]         line,
   output logic [tsw_pkg::X_W-1:0]            start_x,
   output logic                               has_end,
   output logic [tsw_pkg::X_W-1:0]            end_x,
   output logic                               finished
);
   localparam int C       = COORD_BITS;
   localparam int F       = FRAC_BITS;
   localparam int DIFF_W  = C + 1;
   localparam int SLOPE_W = C + F + 1;
   localparam int MUL_W   = C + 2;
   localparam int ACC_W   = SLOPE_W + MUL_W;
   localparam int INT_W   = ACC_W - F;
   localparam int LN_W    = C + 1;
   localparam int XW      = tsw_pkg::X_W;

   logic signed [C-1:0]       vtx_ff [6];
   logic signed [C-1:0]       srt [6];
   logic signed [C-1:0]       tx, ty;
   logic signed [ACC_W-1:0]   acc1_ff, acc2_ff;
   logic signed [SLOPE_W-1:0] slope1_ff, slope2_ff;
   logic signed [ACC_W-1:0]   prod1_ff, prod2_ff;
   logic signed [LN_W-1:0]    line_ff, seg_ff;
   logic                      swap_ff;
   logic signed [INT_W-1:0]   l_ff, r_ff;
   logic                      o_valid_ff, o_end_ff, o_fin_ff;
   logic [tsw_pkg::LINE_W-1:0] o_line_ff;
   logic [XW-1:0]             o_sx_ff, o_ex_ff;

   tsw_pkg::div_kind_type     op_kind;
   logic signed [DIFF_W-1:0]  div_dx, div_dy;
   logic                      div_done;
   logic signed [SLOPE_W-1:0] div_q;

   logic signed [LN_W-1:0]    ybase, yend, act_ext;
   logic signed [MUL_W-1:0]   mult;
   logic signed [ACC_W-1:0]   acc_l, acc_r;
   logic signed [INT_W-1:0]   l_int, r_int, left_ext, right_ext, sx_w, ex_w;
   logic signed [INT_W:0]     span_w;

   function automatic logic signed [ACC_W-1:0] to_fixed(input logic signed [C-1:0] v);
      return {{(ACC_W-C-F){v[C-1]}}, v, {F{1'b0}}};
   endfunction

   function automatic logic signed [INT_W-1:0] int_part(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] b;
      b = v + (v[ACC_W-1] ? ACC_W'((1 << F) - 1) : ACC_W'(0));
      return b[ACC_W-1:F];
   endfunction

   function automatic logic signed [DIFF_W-1:0] diff(input logic signed [C-1:0] a,
                                                   input logic signed [C-1:0] b);
      return DIFF_W'(a) - DIFF_W'(b);
   endfunction

   // three stable compare-swaps on y
   always_comb begin
      tx = '0;
      ty = '0;
      srt[0] = ax; srt[1] = ay; srt[2] = bx; srt[3] = by; srt[4] = cx; srt[5] = cy;
      if (srt[3] < srt[1]) begin
         tx = srt[0]; ty = srt[1];
         srt[0] = srt[2]; srt[1] = srt[3]; srt[2] = tx; srt[3] = ty;
      end
      if (srt[5] < srt[3]) begin
         tx = srt[2]; ty = srt[3];
         srt[2] = srt[4]; srt[3] = srt[5]; srt[4] = tx; srt[5] = ty;
      end
      if (srt[3] < srt[1]) begin
         tx = srt[0]; ty = srt[1];
         srt[0] = srt[2]; srt[1] = srt[3]; srt[2] = tx; srt[3] = ty;
      end
   end

   always_comb begin
      // the top edge division starts in the cycle the long edge slope is stored
      op_kind = cmd.div_kind;
      if (cmd.div_store && cmd.div_kind == tsw_pkg::DIV_TWO) begin
         op_kind = tsw_pkg::DIV_TOP;
      end
      case (op_kind)
         tsw_pkg::DIV_TWO: begin
            div_dx = diff(vtx_ff[4], vtx_ff[0]);
            div_dy = diff(vtx_ff[5], vtx_ff[1]);
         end
         tsw_pkg::DIV_TOP: begin
            div_dx = diff(vtx_ff[2], vtx_ff[0]);
            div_dy = diff(vtx_ff[3], vtx_ff[1]);
         end
         default: begin
            div_dx = diff(vtx_ff[4], vtx_ff[2]);
            div_dy = diff(vtx_ff[5], vtx_ff[3]);
         end
      endcase
   end

   tsw_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .dx    (div_dx),
      .dy    (div_dy),
      .done  (div_done),
      .quot  (div_q)
   );

   // segment entry: skip lines above the screen, clip to active height
   always_comb begin
      ybase   = cmd.enter_bottom ? LN_W'(vtx_ff[3]) : LN_W'(vtx_ff[1]);
      yend    = cmd.enter_bottom ? LN_W'(vtx_ff[5]) : LN_W'(vtx_ff[3]);
      act_ext = LN_W'({1'b0, active_lines});
      mult    = '0;
      if (ybase < 0 && yend > 0) begin
         mult = MUL_W'(0) - MUL_W'(ybase);
      end else if (ybase < 0) begin
         mult = MUL_W'(yend) - MUL_W'(ybase);
      end
   end

   always_comb begin
      acc_l     = swap_ff ? acc2_ff : acc1_ff;
      acc_r     = swap_ff ? acc1_ff : acc2_ff;
      l_int     = int_part(acc_l);
      r_int     = int_part(acc_r);
      left_ext  = INT_W'({1'b0, left_limit});
      right_ext = INT_W'({1'b0, right_limit});
      sx_w      = (l_ff < left_ext) ? left_ext : l_ff;
      if (sx_w > INT_W'(tsw_pkg::X_MAX)) begin
         sx_w = INT_W'(tsw_pkg::X_MAX);
      end
      ex_w = (r_ff > right_ext) ? right_ext : r_ff;
      if (ex_w < 0) begin
         ex_w = '0;
      end
      span_w = (INT_W+1)'(r_ff) - (INT_W+1)'(l_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < 6; k++) begin
            vtx_ff[k] <= srt[k];
         end
      end
      if (cmd.div_store) begin
         if (cmd.div_kind == tsw_pkg::DIV_TWO) begin
            slope2_ff <= div_q;
            if (vtx_ff[3] == vtx_ff[1]) begin
               acc1_ff <= to_fixed(vtx_ff[2]);
            end else begin
               acc1_ff <= to_fixed(vtx_ff[0]);
            end
            acc2_ff <= to_fixed(vtx_ff[0]);
         end else begin
            slope1_ff <= div_q;
         end
      end
      if (cmd.enter) begin
         if (acc1_ff == acc2_ff) begin
            swap_ff <= slope1_ff > slope2_ff;
         end else begin
            swap_ff <= acc1_ff > acc2_ff;
         end
         prod1_ff <= mult * slope1_ff;
         prod2_ff <= mult * slope2_ff;
      end
      if (cmd.enter_add) begin
         acc1_ff <= acc1_ff + prod1_ff;
         acc2_ff <= acc2_ff + prod2_ff;
      end
      if (cmd.step_add) begin
         acc1_ff <= acc1_ff + ACC_W'(slope1_ff);
         acc2_ff <= acc2_ff + ACC_W'(slope2_ff);
      end
      if (cmd.span_calc) begin
         l_ff <= l_int;
         r_ff <= r_int;
      end
      if (cmd.clear_out) begin
         o_valid_ff <= 1'b0;
         o_line_ff  <= '0;
         o_sx_ff    <= '0;
         o_end_ff   <= 1'b0;
         o_ex_ff    <= '0;
      end
      if (cmd.span_out) begin
         o_valid_ff <= 1'b1;
         o_line_ff  <= line_ff[tsw_pkg::LINE_W-1:0];
         o_sx_ff    <= sx_w[XW-1:0];
         o_end_ff   <= span_w > 2;
         o_ex_ff    <= (span_w > 2) ? ex_w[XW-1:0] : '0;
      end
      if (cmd.set_finish) begin
         o_fin_ff <= cmd.finish_val;
      end
      if (reset) begin
         acc1_ff   <= '0;
         acc2_ff   <= '0;
         slope1_ff <= '0;
         slope2_ff <= '0;
         line_ff   <= '0;
         seg_ff    <= '0;
         swap_ff   <= 1'b0;
      end else if (cmd.load) begin
         line_ff <= '0;
         seg_ff  <= '0;
      end else if (cmd.enter) begin
         if (ybase < 0 && yend <= 0) begin
            line_ff <= '0;
            seg_ff  <= '0;
         end else begin
            line_ff <= (ybase < 0) ? LN_W'(0) : ybase;
            seg_ff  <= (yend > act_ext) ? act_ext : yend;
         end
      end else if (cmd.span_out) begin
         line_ff <= line_ff + 1'b1;
      end
   end

   always_comb begin
      status.flat_total = vtx_ff[5] == vtx_ff[1];
      status.flat_top   = vtx_ff[3] == vtx_ff[1];
      status.flat_bot   = vtx_ff[5] == vtx_ff[3];
      status.div_done   = div_done;
      status.need_next  = line_ff >= seg_ff;
   end

   assign span_valid = o_valid_ff;
   assign line       = o_line_ff;
   assign start_x    = o_sx_ff;
   assign has_end    = o_end_ff;
   assign end_x      = o_ex_ff;
   assign finished   = o_fin_ff;
endmodule
`default_nettype wire

// File: design/tsw_ctrl.sv
`default_nettype none
`include "triangle_scanline_span_walker_top_assert.svh"
module tsw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_action,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire tsw_pkg::status_type  status,
   output tsw_pkg::cmd_type          cmd
);
   tsw_pkg::state_type    state_ff, state_in;
   tsw_pkg::phase_type    phase_ff, phase_in;
   tsw_pkg::div_kind_type kind_ff, kind_in;
   logic                  accept;
   logic                  in_add, ph_done;

   assign req_ready = state_ff == tsw_pkg::S_IDLE;
   assign rsp_valid = state_ff == tsw_pkg::S_OUT;
   assign accept    = req_valid && req_ready;
   assign in_add    = state_ff == tsw_pkg::S_ADD;
   assign ph_done   = phase_ff == tsw_pkg::PH_DONE;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsw_pkg::S_IDLE: begin
            if (accept) begin
               if (!req_action) begin
                  state_in = tsw_pkg::S_LOAD;
               end else if (phase_ff == tsw_pkg::PH_DONE) begin
                  state_in = tsw_pkg::S_SETTLE;
               end else begin
                  state_in = tsw_pkg::S_ADD;
               end
            end
         end
         tsw_pkg::S_LOAD: begin
            state_in = status.flat_total ? tsw_pkg::S_SETTLE : tsw_pkg::S_DIV;
         end
         tsw_pkg::S_DIV: begin
            if (status.div_done) begin
               if (kind_ff != tsw_pkg::DIV_TWO) begin
                  state_in = tsw_pkg::S_ENTER;
               end else if (status.flat_top) begin
                  state_in = tsw_pkg::S_SETTLE;
               end
            end
         end
         tsw_pkg::S_ENTER:  state_in = tsw_pkg::S_ENTER2;
         tsw_pkg::S_ENTER2: state_in = tsw_pkg::S_SETTLE;
         tsw_pkg::S_SETTLE: begin
            if (phase_ff == tsw_pkg::PH_DONE || !status.need_next) begin
               state_in = tsw_pkg::S_OUT;
            end else if (phase_ff == tsw_pkg::PH_TOP && !status.flat_bot) begin
               state_in = tsw_pkg::S_DIV;
            end
         end
         tsw_pkg::S_ADD:   state_in = tsw_pkg::S_SPAN;
         tsw_pkg::S_SPAN:  state_in = tsw_pkg::S_CLAMP;
         tsw_pkg::S_CLAMP: state_in = tsw_pkg::S_SETTLE;
         tsw_pkg::S_OUT: begin
            if (rsp_ready) begin
               state_in = tsw_pkg::S_IDLE;
            end
         end
         default: state_in = tsw_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.div_kind = kind_ff;
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      case (state_ff)
         tsw_pkg::S_IDLE: begin
            cmd.load      = accept && !req_action;
            cmd.clear_out = accept;
         end
         tsw_pkg::S_LOAD: begin
            if (status.flat_total) begin
               phase_in = tsw_pkg::PH_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_kind  = tsw_pkg::DIV_TWO;
               kind_in       = tsw_pkg::DIV_TWO;
            end
         end
         tsw_pkg::S_DIV: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               case (kind_ff)
                  tsw_pkg::DIV_TWO: begin
                     phase_in = tsw_pkg::PH_TOP;
                     if (!status.flat_top) begin
                        cmd.div_start = 1'b1;
                        kind_in       = tsw_pkg::DIV_TOP;
                     end
                  end
                  tsw_pkg::DIV_BOT: phase_in = tsw_pkg::PH_BOTTOM;
                  default: ;
               endcase
            end
         end
         tsw_pkg::S_ENTER: begin
            cmd.enter        = 1'b1;
            cmd.enter_bottom = phase_ff == tsw_pkg::PH_BOTTOM;
         end
         tsw_pkg::S_ENTER2: cmd.enter_add = 1'b1;
         tsw_pkg::S_SETTLE: begin
            if (phase_ff == tsw_pkg::PH_DONE || !status.need_next) begin
               cmd.set_finish = 1'b1;
               cmd.finish_val = phase_ff == tsw_pkg::PH_DONE;
            end else if (phase_ff == tsw_pkg::PH_TOP && !status.flat_bot) begin
               cmd.div_start = 1'b1;
               cmd.div_kind  = tsw_pkg::DIV_BOT;
               kind_in       = tsw_pkg::DIV_BOT;
            end else begin
               phase_in = tsw_pkg::PH_DONE;
            end
         end
         tsw_pkg::S_ADD:   cmd.step_add  = 1'b1;
         tsw_pkg::S_SPAN:  cmd.span_calc = 1'b1;
         tsw_pkg::S_CLAMP: cmd.span_out  = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsw_pkg::S_IDLE;
         phase_ff <= tsw_pkg::PH_DONE;
         kind_ff  <= tsw_pkg::DIV_TWO;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
      end
   end

   `TSW_ASSERT(a_one_side, clock, reset, !(req_ready && rsp_valid), "ready while pending")
   `TSW_ASSERT_IMP(a_step_live, clock, reset, in_add, !ph_done, "span step with no triangle")
   `TSW_ASSERT_NXT(a_div_restart, clock, reset, cmd.div_start, !status.div_done, "early done")
   `TSW_ASSERT_IMP(a_enter_live, clock, reset, cmd.enter, !ph_done, "segment entry while done")
endmodule
`default_nettype wire

// File: design/triangle_scanline_span_walker_top.sv
// load: set by serial slope divisions, the long edge first, then the edges of the segments entered
// span step: add, span, clamp and settle states, plus a slope division when the bottom segment is entered
// one item at a time; next request is taken in the cycle after the result transfer
// reset: synchronous active high, no triangle loaded, limits at 480, 224 and 1085
`default_nettype none
module triangle_scanline_span_walker_top #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // ax, ay, bx, by, cx, cy from the lowest bit up
   input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   // action: 0 load triangle, 1 next span
   input  wire logic                                   req_tuser,
   // response channel
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // line, start_x, end_x from the lowest bit up
   output logic [31:0]                                 rsp_tdata,
   // span_valid, has_end from the lowest bit up
   output logic [1:0]                                  rsp_tuser,
   // finished
   output logic                                        rsp_tlast,
   // register write channel
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [tsw_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [tsw_pkg::X_W-1:0]                csr_data
);
   localparam int C = COORD_BITS;

   tsw_pkg::cmd_type    cmd;
   tsw_pkg::status_type status;

   logic [tsw_pkg::LINE_W-1:0] active_ff;
   logic [tsw_pkg::X_W-1:0]    left_ff, right_ff;

   logic                       span_valid, has_end, finished;
   logic [tsw_pkg::LINE_W-1:0] line;
   logic [tsw_pkg::X_W-1:0]    start_x, end_x;

   // registers are always writable; the user must write them only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= tsw_pkg::ACTIVE_RESET;
         left_ff   <= tsw_pkg::LEFT_RESET;
         right_ff  <= tsw_pkg::RIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tsw_pkg::REG_ACTIVE_LINES: active_ff <= csr_data[tsw_pkg::LINE_W-1:0];
            tsw_pkg::REG_LEFT_LIMIT:   left_ff   <= csr_data;
            tsw_pkg::REG_RIGHT_LIMIT:  right_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer: load, divide, segment entry, span steps
   tsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (req_tuser),
      .req_ready  (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // edge accumulators, slopes, clamping and the result register
   tsw_dp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .ax           (req_tdata[0*C +: C]),
      .ay           (req_tdata[1*C +: C]),
      .bx           (req_tdata[2*C +: C]),
      .by           (req_tdata[3*C +: C]),
      .cx           (req_tdata[4*C +: C]),
      .cy           (req_tdata[5*C +: C]),
      .active_lines (active_ff),
      .left_limit   (left_ff),
      .right_limit  (right_ff),
      .span_valid   (span_valid),
      .line         (line),
      .start_x      (start_x),
      .has_end      (has_end),
      .end_x        (end_x),
      .finished     (finished)
   );

   assign rsp_tdata = {end_x, start_x, line};
   assign rsp_tuser = {has_end, span_valid};
   assign rsp_tlast = finished;
endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none

// one expected response of the span walker
typedef struct {
   bit          span_valid;
   bit [9:0]    line;
   bit [10:0]   start_x;
   bit          has_end;
   bit [10:0]   end_x;
   bit          finished;
} span_rsp_type;

// edge-walking predictor plus the queue of spans still owed by the block
class span_scoreboard;
   tsw_pkg::phase_type phase;
   int        vert[6];
   longint    acc_one, acc_two, slope_one, slope_two;
   int        line_cnt, seg_end;
   bit        swapped;
   int        active_lines, left_limit, right_limit;
   span_rsp_type owed[$];
   int        errors;

   function new();
      phase = tsw_pkg::PH_DONE;
      acc_one = 0; acc_two = 0; slope_one = 0; slope_two = 0;
      line_cnt = 0; seg_end = 0; swapped = 0;
      active_lines = 480; left_limit = 224; right_limit = 1085;
      errors = 0;
   endfunction

   function void set_reg(logic [tsw_pkg::CSR_IDX_W-1:0] idx, int value);
      case (idx)
         tsw_pkg::REG_ACTIVE_LINES: active_lines = value & 'h3ff;
         tsw_pkg::REG_LEFT_LIMIT:   left_limit = value & 'h7ff;
         tsw_pkg::REG_RIGHT_LIMIT:  right_limit = value & 'h7ff;
         default: ;
      endcase
   endfunction

   function longint slope_of(int dx, int dy);
      return (longint'(dx) * 65536) / longint'(dy);
   endfunction

   function void enter_segment(int ybase, int yend);
      if (acc_one == acc_two) swapped = slope_one > slope_two;
      else swapped = acc_one > acc_two;
      if (ybase < 0 && yend > 0) begin
         acc_one += longint'(-ybase) * slope_one;
         acc_two += longint'(-ybase) * slope_two;
         ybase = 0;
      end else if (ybase < 0) begin
         // segment entirely above the screen: just walk past it
         acc_one += longint'(yend - ybase) * slope_one;
         acc_two += longint'(yend - ybase) * slope_two;
         line_cnt = 0;
         seg_end = 0;
         return;
      end
      if (yend > active_lines) yend = active_lines;
      line_cnt = ybase;
      seg_end = yend;
   endfunction

   function void settle();
      int dy;
      while (phase != tsw_pkg::PH_DONE && line_cnt >= seg_end) begin
         if (phase == tsw_pkg::PH_TOP) begin
            dy = vert[5] - vert[3];
            if (dy != 0) begin
               slope_one = slope_of(vert[4] - vert[2], dy);
               enter_segment(vert[3], vert[5]);
               phase = tsw_pkg::PH_BOTTOM;
            end else phase = tsw_pkg::PH_DONE;
         end else phase = tsw_pkg::PH_DONE;
      end
   endfunction

   function void load_triangle(logic [71:0] data);
      int v[6];
      int a, b, tx, ty;
      int pa[3] = '{0, 1, 0};
      int pb[3] = '{1, 2, 1};
      for (int k = 0; k < 6; k++) v[k] = int'($signed(data[k*12 +: 12]));
      // three stable compare-swaps on y
      for (int k = 0; k < 3; k++) begin
         a = pa[k] * 2; b = pb[k] * 2;
         if (v[b+1] < v[a+1]) begin
            tx = v[a]; ty = v[a+1];
            v[a] = v[b]; v[a+1] = v[b+1];
            v[b] = tx; v[b+1] = ty;
         end
      end
      vert = v;
      line_cnt = 0;
      seg_end = 0;
      if (v[5] - v[1] == 0) begin
         phase = tsw_pkg::PH_DONE;
         return;
      end
      slope_two = slope_of(v[4] - v[0], v[5] - v[1]);
      phase = tsw_pkg::PH_TOP;
      if (v[3] - v[1] != 0) begin
         acc_one = longint'(v[0]) * 65536;
         acc_two = acc_one;
         slope_one = slope_of(v[2] - v[0], v[3] - v[1]);
         enter_segment(v[1], v[3]);
      end else begin
         acc_one = longint'(v[2]) * 65536;
         acc_two = longint'(v[0]) * 65536;
      end
      settle();
   endfunction

   // accepted request: compute the span the block owes for it
   function void note_request(bit action, logic [71:0] data);
      span_rsp_type r;
      longint l, rr, sx, ex;
      r = '{default: 0};
      if (action == 1'b0) begin
         load_triangle(data);
         r.finished = phase == tsw_pkg::PH_DONE;
      end else if (phase == tsw_pkg::PH_DONE) begin
         r.finished = 1;
      end else begin
         acc_one += slope_one;
         acc_two += slope_two;
         l = (swapped ? acc_two : acc_one) / 65536;
         rr = (swapped ? acc_one : acc_two) / 65536;
         sx = l < left_limit ? left_limit : l;
         if (sx > tsw_pkg::X_MAX) sx = tsw_pkg::X_MAX;
         r.span_valid = 1;
         r.line = line_cnt[9:0];
         r.start_x = sx[10:0];
         if (rr - l > 2) begin
            ex = rr > right_limit ? right_limit : rr;
            if (ex < 0) ex = 0;
            r.has_end = 1;
            r.end_x = ex[10:0];
         end
         line_cnt++;
         settle();
         r.finished = phase == tsw_pkg::PH_DONE;
      end
      owed.push_back(r);
   endfunction

   task report(string field, int got, int want);
      $display("%0t: %s got %0d expected %0d", $realtime, field, got, want);
      errors++;
   endtask

   task check_response(logic [31:0] data, logic [1:0] user, logic last);
      span_rsp_type e;
      if (owed.size() == 0) begin
         report("unexpected transfer, line", data[9:0], -1);
         return;
      end
      e = owed.pop_front();
      if (user[0] !== e.span_valid) report("span_valid", user[0], e.span_valid);
      if (data[9:0] !== e.line) report("line", data[9:0], e.line);
      if (data[20:10] !== e.start_x) report("start_x", data[20:10], e.start_x);
      if (user[1] !== e.has_end) report("has_end", user[1], e.has_end);
      if (data[31:21] !== e.end_x) report("end_x", data[31:21], e.end_x);
      if (last !== e.finished) report("finished", last, e.finished);
   endtask
endclass

module tb_top;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;  // ax, ay, bx, by, cx, cy from bit 0 up
   logic        req_tuser = 0;   // action
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;       // line, start_x, end_x from bit 0 up
   logic [1:0]  rsp_tuser;       // span_valid, has_end from bit 0 up
   logic        rsp_tlast;       // finished
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [tsw_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tsw_pkg::X_W-1:0]       csr_data = '0;

   span_scoreboard spans = new();
   int  sent;        // requests transferred so far
   int  rsp_seen;    // responses transferred so far

   triangle_scanline_span_walker_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // mostly short gaps, now and then a long one, sometimes none at all
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one request transfer; valid stays high across back-to-back transfers
   task send_request(bit action, logic [71:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= action;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      spans.note_request(action, data);
      sent++;
   endtask

   function logic [71:0] pack_tri(int ax, int ay, int bx, int by, int cx, int cy);
      logic [71:0] d;
      d[11:0] = ax[11:0]; d[23:12] = ay[11:0]; d[35:24] = bx[11:0];
      d[47:36] = by[11:0]; d[59:48] = cx[11:0]; d[71:60] = cy[11:0];
      return d;
   endfunction

   function logic [71:0] noise();
      return {$urandom, $urandom, $urandom};
   endfunction

   // load, then walk lines until finished or a step limit
   task walk_triangle(logic [71:0] tri_data, int max_steps);
      int n;
      send_request(1'b0, tri_data);
      n = 0;
      while (spans.phase != tsw_pkg::PH_DONE && n < max_steps) begin
         send_request(1'b1, noise());
         n++;
      end
   endtask

   // register writes only once the block has drained
   task write_reg(logic [tsw_pkg::CSR_IDX_W-1:0] idx, int value);
      req_tvalid <= 0;
      while (spans.owed.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value[10:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      spans.set_reg(idx, value);
   endtask

   task set_regs(int lines, int lo, int hi);
      write_reg(tsw_pkg::REG_ACTIVE_LINES, lines);
      write_reg(tsw_pkg::REG_LEFT_LIMIT, lo);
      write_reg(tsw_pkg::REG_RIGHT_LIMIT, hi);
   endtask

   function logic [71:0] rand_tri();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return noise();     // full coordinate range
      return pack_tri($urandom_range(0, 1400), $urandom_range(0, 110) - 40,
                      $urandom_range(0, 1400), $urandom_range(0, 110) - 40,
                      $urandom_range(0, 1400), $urandom_range(0, 110) - 40);
   endfunction

   task random_phase(int count);
      int goal;
      goal = sent + count;
      while (sent < goal) begin
         if ($urandom_range(0, 9) == 0) send_request($urandom_range(0, 1), noise());
         else walk_triangle(rand_tri(), $urandom_range(0, 7) == 0 ?
                            $urandom_range(0, 5) : 60);
      end
   endtask

   // response side: random stalls and one long hold-off to back up the input
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            spans.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
            rsp_seen++;
         end
         if (rsp_seen == 40) begin
            rsp_tready <= 0;
            hold = 400;
            rsp_seen++;
            repeat (hold) @(posedge clock);
         end else begin
            rsp_tready <= (pick_gap() == 0);
         end
      end
   end

   // overall limit
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // step with nothing loaded
      send_request(1'b1, noise());
      set_regs(480, 224, 1085);
      // extreme vertices, full-scale slopes
      walk_triangle(pack_tri(-2048, -2048, 2047, 2047, -2048, 2047), 30);
      walk_triangle(pack_tri(2047, 2047, -2048, -2048, 2047, -2048), 30);
      // zero-height triangle
      walk_triangle(pack_tri(300, 10, 500, 10, 700, 10), 5);
      // flat top and flat bottom
      walk_triangle(pack_tri(300, 5, 600, 5, 450, 10), 10);
      walk_triangle(pack_tri(450, 2, 300, 7, 600, 7), 10);
      // stable sort with equal y, wide span clamped on both sides
      walk_triangle(pack_tri(0, 3, 1500, 3, 700, 6), 10);
      // segments above the screen: one ending above, one crossing line 0
      walk_triangle(pack_tri(400, -20, 420, -10, 700, 4), 10);
      walk_triangle(pack_tri(400, -5, 500, 0, 300, 3), 10);
      // equal start, order by slope
      walk_triangle(pack_tri(500, 0, 480, 4, 520, 4), 10);
      // load while a triangle is still in progress
      walk_triangle(pack_tri(400, 0, 900, 50, 300, 90), 3);

      set_regs(1, 0, 2047);
      random_phase(80);
      set_regs(1023, 2047, 0);
      random_phase(100);
      set_regs(60, 0, 2047);
      random_phase(120);
      set_regs($urandom_range(1, 1023), $urandom_range(0, 2047), $urandom_range(0, 2047));
      random_phase(150);

      req_tvalid <= 0;
      while (spans.owed.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (spans.errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

`default_nettype wire

// File: triangle_scanline_span_walker_top.f
+incdir+design
design/tsw_pkg.sv
design/tsw_div.sv
design/tsw_dp.sv
design/tsw_ctrl.sv
design/triangle_scanline_span_walker_top.sv
tb/tb_top.sv
